// ===== rtl/slag_pkg.sv =====
// Shared types and constants for the staple link address generator.
`timescale 1ns / 1ps
`default_nettype none

package slag_pkg;

   localparam int NUM_DIRS = 4;
   localparam int COORD_W  = 6;
   localparam int EXT_W    = 7;
   localparam int SITE_W   = 24;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // register indexes of the configuration space
   localparam logic [1:0] REG_EXTENT_X = 2'd0;
   localparam logic [1:0] REG_EXTENT_Y = 2'd1;
   localparam logic [1:0] REG_EXTENT_Z = 2'd2;
   localparam logic [1:0] REG_EXTENT_T = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [COORD_W-1:0] coord_t;
      logic [1:0]         link_dir;
   } req_type;

   typedef struct packed {
      logic [2:0]        staple_number;
      logic [1:0]        link_slot;
      logic [SITE_W-1:0] site_index;
      logic [1:0]        staple_dir;
      logic              out_of_range;
      logic              last;
   } rsp_type;

   typedef logic [NUM_DIRS-1:0][COORD_W-1:0] coord_arr_type;
   typedef logic [NUM_DIRS-1:0][EXT_W-1:0]   ext_arr_type;
   typedef logic [NUM_DIRS-1:0][EXT_W-1:0]   step_arr_type;

   // fields that ride along the pipeline untouched
   typedef struct packed {
      logic [2:0] staple_number;
      logic [1:0] link_slot;
      logic [1:0] staple_dir;
      logic       out_of_range;
      logic       last;
   } tag_type;

   // one issued link address: base site plus the neighbor steps to take
   typedef struct packed {
      coord_arr_type coord;
      logic [1:0]    mu;
      logic [1:0]    nu;
      logic          mu_fwd;
      logic          nu_fwd;
      logic          nu_back;
      tag_type       tag;
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/slag_sequencer.sv =====
// Request holder and sequencer that issues the eighteen staple link ops (one flagged op if out of range).
`timescale 1ns / 1ps
`default_nettype none

module slag_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire slag_pkg::req_type    req_data,
   input  wire slag_pkg::ext_arr_type ext,
   output logic                      op_valid,
   output slag_pkg::op_type          op
);
   import slag_pkg::*;

   localparam logic [2:0] SUB_FWD_0  = 3'd0;
   localparam logic [2:0] SUB_FWD_1  = 3'd1;
   localparam logic [2:0] SUB_FWD_2  = 3'd2;
   localparam logic [2:0] SUB_BACK_0 = 3'd3;
   localparam logic [2:0] SUB_BACK_1 = 3'd4;
   localparam logic [2:0] SUB_BACK_2 = 3'd5;
   localparam logic [1:0] LAST_NU    = 2'd2;

   logic          busy_ff, busy_in;
   req_type       req_ff, req_in;
   logic [2:0]    sub_ff, sub_in;
   logic [1:0]    nuidx_ff, nuidx_in;
   coord_arr_type base;
   logic          oor;
   logic          last_op;
   logic          accept;
   logic [1:0]    nu;
   logic          is_back;

   assign base[0] = req_ff.coord_x;
   assign base[1] = req_ff.coord_y;
   assign base[2] = req_ff.coord_z;
   assign base[3] = req_ff.coord_t;

   always_comb begin
      oor = 1'b0;
      for (int k = 0; k < NUM_DIRS; k++) begin
         if ({1'b0, base[k]} >= ext[k]) begin
            oor = 1'b1;
         end
      end
   end

   assign nu      = nuidx_ff + {1'b0, (nuidx_ff >= req_ff.link_dir)};
   assign is_back = (sub_ff >= SUB_BACK_0);
   assign last_op = oor || ((nuidx_ff == LAST_NU) && (sub_ff == SUB_BACK_2));

   assign op_valid  = busy_ff;
   assign req_ready = !busy_ff || (advance && last_op);
   assign accept    = req_valid && req_ready;

   always_comb begin
      op.coord             = base;
      op.mu                = req_ff.link_dir;
      op.nu                = nu;
      op.mu_fwd            = 1'b0;
      op.nu_fwd            = 1'b0;
      op.nu_back           = 1'b0;
      op.tag.staple_number = {nuidx_ff, is_back};
      op.tag.link_slot     = is_back ? 2'(sub_ff - SUB_BACK_0) : sub_ff[1:0];
      op.tag.staple_dir    = nu;
      op.tag.out_of_range  = 1'b0;
      op.tag.last          = last_op;
      unique case (sub_ff)
         SUB_FWD_0: begin
            op.mu_fwd = 1'b1;
         end
         SUB_FWD_1: begin
            op.nu_fwd         = 1'b1;
            op.tag.staple_dir = req_ff.link_dir;
         end
         SUB_FWD_2: begin
            // base site itself, no step
         end
         SUB_BACK_0: begin
            op.mu_fwd  = 1'b1;
            op.nu_back = 1'b1;
         end
         SUB_BACK_1: begin
            op.nu_back        = 1'b1;
            op.tag.staple_dir = req_ff.link_dir;
         end
         SUB_BACK_2: begin
            op.nu_back = 1'b1;
         end
         default: begin
         end
      endcase
      // a rejected request gives one flagged, final result with its step and staple fields cleared
      if (oor) begin
         op.mu_fwd            = 1'b0;
         op.nu_fwd            = 1'b0;
         op.nu_back           = 1'b0;
         op.tag.staple_number = '0;
         op.tag.link_slot     = '0;
         op.tag.staple_dir    = '0;
         op.tag.out_of_range  = 1'b1;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      req_in   = req_ff;
      sub_in   = sub_ff;
      nuidx_in = nuidx_ff;
      if (busy_ff && advance) begin
         if (last_op) begin
            busy_in = 1'b0;
         end else if (sub_ff == SUB_BACK_2) begin
            sub_in   = SUB_FWD_0;
            nuidx_in = nuidx_ff + 2'd1;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         req_in   = req_data;
         sub_in   = SUB_FWD_0;
         nuidx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         req_ff   <= '0;
         sub_ff   <= SUB_FWD_0;
         nuidx_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         req_ff   <= req_in;
         sub_ff   <= sub_in;
         nuidx_ff <= nuidx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slag_neighbor.sv =====
// Neighbor stage: periodic forward and backward steps of the base site.
`timescale 1ns / 1ps
`default_nettype none

module slag_neighbor (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  op_valid,
   input  wire slag_pkg::op_type      op,
   input  wire slag_pkg::ext_arr_type ext,
   output logic                       nb_valid,
   output slag_pkg::step_arr_type     nb_coord,
   output slag_pkg::tag_type          nb_tag
);
   import slag_pkg::*;

   logic         valid_ff;
   step_arr_type coord_ff, coord_in;
   tag_type      tag_ff;

   always_comb begin
      for (int k = 0; k < NUM_DIRS; k++) begin
         logic [EXT_W-1:0] c;
         logic [EXT_W-1:0] inc;
         logic             fwd;
         logic             back;
         c    = {1'b0, op.coord[k]};
         inc  = c + 7'd1;
         fwd  = (op.mu_fwd && (op.mu == 2'(k))) || (op.nu_fwd && (op.nu == 2'(k)));
         back = op.nu_back && (op.nu == 2'(k));
         if (op.tag.out_of_range) begin
            coord_in[k] = '0;
         end else if (fwd) begin
            coord_in[k] = (inc >= ext[k]) ? '0 : inc;
         end else if (back) begin
            coord_in[k] = (c == '0) ? ext[k] - 7'd1 : c - 7'd1;
         end else begin
            coord_in[k] = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coord_ff <= coord_in;
         tag_ff   <= op.tag;
      end
   end

   assign nb_valid = valid_ff;
   assign nb_coord = coord_ff;
   assign nb_tag   = tag_ff;

endmodule

`default_nettype wire

// ===== rtl/slag_index.sv =====
// Linear site index pipeline: one multiply-add per stage, t down to x.
`timescale 1ns / 1ps
`default_nettype none

module slag_index (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   nb_valid,
   input  wire slag_pkg::step_arr_type nb_coord,
   input  wire slag_pkg::tag_type      nb_tag,
   input  wire slag_pkg::ext_arr_type  ext,
   output logic                        rsp_valid,
   output slag_pkg::rsp_type           rsp_data
);
   import slag_pkg::*;

   localparam int V2_W = 2 * EXT_W + 1;
   localparam int V1_W = 3 * EXT_W + 2;

   logic              s2_valid_ff;
   logic [EXT_W-1:0]  s2_c0_ff, s2_c1_ff;
   logic [V2_W-1:0]   s2_v_ff;
   tag_type           s2_tag_ff;

   logic              s3_valid_ff;
   logic [EXT_W-1:0]  s3_c0_ff;
   logic [V1_W-1:0]   s3_v_ff;
   tag_type           s3_tag_ff;

   logic              s4_valid_ff;
   logic [SITE_W-1:0] s4_site_ff;
   tag_type           s4_tag_ff;

   logic [V2_W-1:0]   s2_v_in;
   logic [V1_W-1:0]   s3_v_in;
   logic [SITE_W-1:0] s4_site_in;

   assign s2_v_in    = V2_W'(nb_coord[2]) + V2_W'(ext[2]) * V2_W'(nb_coord[3]);
   assign s3_v_in    = V1_W'(s2_c1_ff) + V1_W'(ext[1]) * V1_W'(s2_v_ff);
   // the index wraps at the site field width
   assign s4_site_in = SITE_W'(s3_c0_ff) + SITE_W'(ext[0]) * SITE_W'(s3_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= nb_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_c0_ff   <= nb_coord[0];
         s2_c1_ff   <= nb_coord[1];
         s2_v_ff    <= s2_v_in;
         s2_tag_ff  <= nb_tag;
         s3_c0_ff   <= s2_c0_ff;
         s3_v_ff    <= s3_v_in;
         s3_tag_ff  <= s2_tag_ff;
         s4_site_ff <= s4_site_in;
         s4_tag_ff  <= s3_tag_ff;
      end
   end

   assign rsp_valid              = s4_valid_ff;
   assign rsp_data.staple_number = s4_tag_ff.staple_number;
   assign rsp_data.link_slot     = s4_tag_ff.link_slot;
   assign rsp_data.site_index    = s4_site_ff;
   assign rsp_data.staple_dir    = s4_tag_ff.staple_dir;
   assign rsp_data.out_of_range  = s4_tag_ff.out_of_range;
   assign rsp_data.last          = s4_tag_ff.last;

endmodule

`default_nettype wire

// ===== rtl/staple_link_address_generator.sv =====
// Top level: configuration registers, sequencer and address pipeline.
// A request's first result passes the sequencer, neighbor and index registers.
// Throughput: one result per cycle unless the output stalls; a request gives
// eighteen results (one if rejected), one link op each into a 4-stage pipeline.
// The next request is taken in the cycle the previous one issues its last op.
// Synchronous reset clears the pipeline, the sequencer and sets all extents to 8.
`timescale 1ns / 1ps
`default_nettype none

module staple_link_address_generator #(
   parameter int MAX_EXTENT = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire slag_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output slag_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [slag_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [slag_pkg::DATA_W-1:0]   pwdata,
   output logic [slag_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import slag_pkg::*;

   localparam int               CLAMP   = (MAX_EXTENT > 127) ? 127 : MAX_EXTENT;
   localparam logic [EXT_W-1:0] CLAMP_V = EXT_W'(CLAMP);
   localparam logic [EXT_W-1:0] EXT_RST = 7'd8;

   ext_arr_type extent_ff;
   ext_arr_type ext;
   logic        advance;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic        op_valid;
   op_type      op;
   logic        nb_valid;
   step_arr_type nb_coord;
   tag_type     nb_tag;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DIRS; k++) begin
            extent_ff[k] <= EXT_RST;
         end
      end else if (csr_write) begin
         extent_ff[csr_index] <= pwdata[EXT_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_EXTENT_X: prdata = DATA_W'(extent_ff[0]);
         REG_EXTENT_Y: prdata = DATA_W'(extent_ff[1]);
         REG_EXTENT_Z: prdata = DATA_W'(extent_ff[2]);
         REG_EXTENT_T: prdata = DATA_W'(extent_ff[3]);
         default:      prdata = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < NUM_DIRS; k++) begin
         ext[k] = (extent_ff[k] > CLAMP_V) ? CLAMP_V : extent_ff[k];
      end
   end

   // hold the whole pipeline while a result waits at the output
   assign advance = !rsp_valid || rsp_ready;

   slag_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .ext       (ext),
      .op_valid  (op_valid),
      .op        (op)
   );

   slag_neighbor u_neighbor (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .op_valid (op_valid),
      .op       (op),
      .ext      (ext),
      .nb_valid (nb_valid),
      .nb_coord (nb_coord),
      .nb_tag   (nb_tag)
   );

   slag_index u_index (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .nb_valid  (nb_valid),
      .nb_coord  (nb_coord),
      .nb_tag    (nb_tag),
      .ext       (ext),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/slag_checker.sv =====
// Port-level checks for the staple link address generator, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module slag_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire slag_pkg::rsp_type rsp_data
);
   import slag_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a rejected request gives one cleared, final result
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.last && (rsp_data.site_index == '0) &&
         (rsp_data.staple_number == 3'd0) && (rsp_data.link_slot == 2'd0))
      else $error("bad rejected result");

   // the final result of an accepted request closes the sixth staple
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last && !rsp_data.out_of_range |->
         (rsp_data.staple_number == 3'd5) && (rsp_data.link_slot == 2'd2))
      else $error("last result at wrong position");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind staple_link_address_generator slag_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
